// ===== src/lbcd_pkg.sv =====
// Package of the buffer cache directory: request and result beats,
// buffer cell commands and the sequencer states. No dependencies.
package lbcd_pkg;

	localparam int MAX_RESULTS = 16;

	typedef enum logic [2:0] {
		ACT_GET          = 3'd0,
		ACT_MARK         = 3'd1,
		ACT_LOCK         = 3'd2,
		ACT_UNLOCK       = 3'd3,
		ACT_FLUSH_FILE   = 3'd4,
		ACT_PURGE_FILE   = 3'd5,
		ACT_FLUSH_ALL    = 3'd6,
		ACT_PURGE_ALL    = 3'd7
	} action_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [7:0]  file_id;
		logic [31:0] record_number;
		logic [1:0]  request_flags;
		logic [3:0]  target_buffer;
	} req_t;

	typedef struct packed {
		logic [3:0]  buffer_index;
		logic        hit;
		logic        error_code;
		logic        writeback_needed;
		logic [7:0]  writeback_file;
		logic [31:0] writeback_record;
		logic        read_needed;
		logic [31:0] hits_so_far;
		logic        last;
	} result_t;

	typedef enum logic [3:0] {
		C_NOP, C_FLAGS, C_MARK, C_LOCK, C_UNLOCK, C_ASSIGN,
		C_FLUSHED, C_DISCARD, C_SET_NEXT, C_SET_PREV
	} cell_op_t;

	typedef struct packed {
		cell_op_t   op;
		logic [1:0] flags;
	} cell_cmd_t;

	typedef struct packed {
		logic        in_use;
		logic        upd;
		logic [7:0]  lock;
		logic [7:0]  file;
		logic [31:0] rec;
	} cell_view_t;

	typedef enum logic [2:0] {
		S_IDLE, S_TGT, S_GET, S_MOVE, S_VICT, S_FLUSH, S_FEND, S_PURGE
	} state_t;

endpackage

// ===== src/lbcd_cell.sv =====
// One buffer of the directory: owner, marks, lock count and recency links.
// Takes part in the lookup chain. Depends on lbcd_pkg.
module lbcd_cell #(
	parameter int NUM_BUFFERS = 16,
	parameter int IW = 4,
	parameter int IDX = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lbcd_pkg::cell_cmd_t cmd,
	input  logic [IW-1:0]      sel_idx,
	input  logic [IW-1:0]      link_val,
	input  logic [7:0]         req_file,
	input  logic [31:0]        req_rec,
	input  logic               hit_in,
	input  logic [IW-1:0]      hit_idx_in,
	output logic               hit_out,
	output logic [IW-1:0]      hit_idx_out,
	output lbcd_pkg::cell_view_t view,
	output logic [IW-1:0]      next_o,
	output logic [IW-1:0]      prev_o
);
	import lbcd_pkg::*;

	localparam logic [IW-1:0] MY_IDX = IW'(IDX);
	localparam logic [IW-1:0] NEXT_RST = IW'((IDX + 1) % NUM_BUFFERS);
	localparam logic [IW-1:0] PREV_RST = IW'((IDX + NUM_BUFFERS - 1) % NUM_BUFFERS);

	logic        in_use_q, upd_q, new_q;
	logic [7:0]  lock_q, file_q;
	logic [31:0] rec_q;
	logic [IW-1:0] next_q, prev_q;
	logic sel, mine;

	assign sel = (sel_idx == MY_IDX);
	assign mine = in_use_q && (file_q == req_file) && (rec_q == req_rec);
	assign hit_out = hit_in | mine;
	assign hit_idx_out = hit_in ? hit_idx_in : MY_IDX;
	assign view = '{in_use: in_use_q, upd: upd_q, lock: lock_q, file: file_q, rec: rec_q};
	assign next_o = next_q;
	assign prev_o = prev_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			upd_q <= 1'b0;
			new_q <= 1'b0;
			lock_q <= '0;
			file_q <= '0;
			rec_q <= '0;
			next_q <= NEXT_RST;
			prev_q <= PREV_RST;
		end else if (sel) begin
			case (cmd.op)
				C_FLAGS: begin
					if (cmd.flags[0]) upd_q <= 1'b1;
					if (cmd.flags[1]) new_q <= 1'b1;
				end
				C_MARK: begin
					if (in_use_q) upd_q <= 1'b1;
				end
				C_LOCK: begin
					if (lock_q != 8'hFF) lock_q <= lock_q + 8'd1;
				end
				C_UNLOCK: begin
					if (lock_q != 8'h00) lock_q <= lock_q - 8'd1;
				end
				C_ASSIGN: begin
					if (in_use_q) lock_q <= '0;
					in_use_q <= 1'b1;
					file_q <= req_file;
					rec_q <= req_rec;
					upd_q <= cmd.flags[0];
					new_q <= cmd.flags[1];
				end
				C_FLUSHED: begin
					upd_q <= 1'b0;
					new_q <= 1'b0;
				end
				C_DISCARD: begin
					in_use_q <= 1'b0;
					upd_q <= 1'b0;
					new_q <= 1'b0;
					lock_q <= '0;
					file_q <= '0;
					rec_q <= '0;
				end
				C_SET_NEXT: next_q <= link_val;
				C_SET_PREV: prev_q <= link_val;
				default: ;
			endcase
		end
	end

endmodule

// ===== src/lru_buffer_cache_directory.sv =====
// Top level of the buffer cache directory: request sequencer and the row of
// buffer cells. Depends on lbcd_pkg and lbcd_cell.
//
// A request beat is taken at a clock edge with start high and busy low.
// Results leave on result with result_valid high for one cycle each; the
// receiver must take them, it cannot stall the block. The final result of a
// request has last set. Busy falls in the cycle that carries it, or, when a get
// hit relinks the buffer, only once the relinking is done.
// A get that hits the most recent or the least recent buffer needs no
// relinking; any other hit is relinked to the recent end. On a miss it
// visits buffers along the recency links from the least recent one until
// one is free or unlocked, else it reports an error. Mark, lock and unlock
// act on the target buffer directly. Flush and purge walk every buffer in
// index order, one a cycle. The cells hold one operation per cycle. Reset
// empties every buffer, clears the hit count and puts the links in index
// order with the last buffer most recent.
module lru_buffer_cache_directory #(
	parameter int NUM_BUFFERS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  lbcd_pkg::req_t    req,
	output logic              result_valid,
	output lbcd_pkg::result_t result
);
	import lbcd_pkg::*;

	localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(NUM_BUFFERS - 1);
	localparam int KW = $clog2(MAX_RESULTS + 1);

	state_t state_q, state_d;
	req_t req_q;
	logic [IW-1:0] cnt_q, h_q, mru_q, n_q, p_q, m_q, nm_q;
	logic [2:0] mstep_q;
	logic [31:0] hit_total_q;
	logic [KW-1:0] k_q;
	logic pend_v_q;
	result_t pend_q, res_q;
	logic res_v_q;

	cell_cmd_t cmd;
	logic [IW-1:0] sel_idx, link_val;
	logic hit_c [NUM_BUFFERS+1];
	logic [IW-1:0] hidx_c [NUM_BUFFERS+1];
	cell_view_t view [NUM_BUFFERS];
	logic [IW-1:0] nxt [NUM_BUFFERS];
	logic [IW-1:0] prv [NUM_BUFFERS];

	assign hit_c[0] = 1'b0;
	assign hidx_c[0] = '0;

	for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
		lbcd_cell #(.NUM_BUFFERS(NUM_BUFFERS), .IW(IW), .IDX(g)) u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(cmd), .sel_idx(sel_idx),
			.link_val(link_val), .req_file(req_q.file_id), .req_rec(req_q.record_number),
			.hit_in(hit_c[g]), .hit_idx_in(hidx_c[g]), .hit_out(hit_c[g+1]),
			.hit_idx_out(hidx_c[g+1]), .view(view[g]), .next_o(nxt[g]), .prev_o(prv[g])
		);
	end

	logic hit_any;
	logic [IW-1:0] hit_idx, cand, fi;
	logic tgt_ok, cand_ok, fmatch, pmatch, is_all;
	cell_view_t cv, fv;
	result_t emit_d, blank;
	logic emit;

	assign hit_any = hit_c[NUM_BUFFERS];
	assign hit_idx = hidx_c[NUM_BUFFERS];
	assign tgt_ok = (32'(req_q.target_buffer) < 32'(NUM_BUFFERS));
	assign cand = nxt[h_q];
	assign cv = view[cand];
	assign cand_ok = !cv.in_use || (cv.lock == 8'd0);
	assign fi = cnt_q;
	assign fv = view[fi];
	assign is_all = req_q.action[1];
	assign fmatch = fv.in_use && fv.upd && (is_all || fv.file == req_q.file_id)
		&& (32'(k_q) < 32'(MAX_RESULTS));
	assign pmatch = fv.in_use && (is_all || fv.file == req_q.file_id);

	always_comb begin
		blank = '0;
		blank.hits_so_far = hit_total_q;
		blank.last = 1'b1;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (action_t'(req.action))
						ACT_GET: state_d = S_GET;
						ACT_MARK, ACT_LOCK, ACT_UNLOCK: state_d = S_TGT;
						ACT_FLUSH_FILE, ACT_FLUSH_ALL: state_d = S_FLUSH;
						default: state_d = S_PURGE;
					endcase
				end
			end
			S_TGT: state_d = S_IDLE;
			S_GET: begin
				if (!hit_any) state_d = S_VICT;
				else if (hit_idx != mru_q && nxt[mru_q] != hit_idx) state_d = S_MOVE;
				else state_d = S_IDLE;
			end
			S_MOVE: if (mstep_q == 3'd5) state_d = S_IDLE;
			S_VICT: if (cand_ok || cnt_q == LAST_IDX) state_d = S_IDLE;
			S_FLUSH: if (cnt_q == LAST_IDX) state_d = S_FEND;
			S_FEND: state_d = S_IDLE;
			S_PURGE: if (cnt_q == LAST_IDX) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '{op: C_NOP, flags: req_q.request_flags};
		sel_idx = '0;
		link_val = '0;
		emit = 1'b0;
		emit_d = blank;
		case (state_q)
			S_TGT: begin
				sel_idx = IW'(req_q.target_buffer);
				if (tgt_ok) begin
					case (action_t'(req_q.action))
						ACT_MARK: cmd.op = C_MARK;
						ACT_LOCK: cmd.op = C_LOCK;
						default: cmd.op = C_UNLOCK;
					endcase
				end
				emit = 1'b1;
				emit_d.buffer_index = req_q.target_buffer;
			end
			S_GET: begin
				if (hit_any) begin
					cmd.op = C_FLAGS;
					sel_idx = hit_idx;
					emit = 1'b1;
					emit_d.buffer_index = 4'(hit_idx);
					emit_d.hit = 1'b1;
					emit_d.hits_so_far = hit_total_q + 32'd1;
				end
			end
			S_MOVE: begin
				case (mstep_q)
					3'd0: begin cmd.op = C_SET_PREV; sel_idx = n_q; link_val = p_q; end
					3'd1: begin cmd.op = C_SET_NEXT; sel_idx = p_q; link_val = n_q; end
					3'd2: begin cmd.op = C_SET_PREV; sel_idx = h_q; link_val = m_q; end
					3'd3: begin cmd.op = C_SET_NEXT; sel_idx = h_q; link_val = nm_q; end
					3'd4: begin cmd.op = C_SET_PREV; sel_idx = nm_q; link_val = h_q; end
					default: begin cmd.op = C_SET_NEXT; sel_idx = m_q; link_val = h_q; end
				endcase
			end
			S_VICT: begin
				if (cand_ok) begin
					cmd.op = C_ASSIGN;
					sel_idx = cand;
					emit = 1'b1;
					emit_d.buffer_index = 4'(cand);
					if (cv.in_use && cv.upd) begin
						emit_d.writeback_needed = 1'b1;
						emit_d.writeback_file = cv.file;
						emit_d.writeback_record = cv.rec;
					end
					emit_d.read_needed = !req_q.request_flags[1];
				end else if (cnt_q == LAST_IDX) begin
					emit = 1'b1;
					emit_d.error_code = 1'b1;
				end
			end
			S_FLUSH: begin
				sel_idx = fi;
				if (fmatch) begin
					cmd.op = C_FLUSHED;
					if (pend_v_q) begin
						emit = 1'b1;
						emit_d = pend_q;
					end
				end
			end
			S_FEND: begin
				emit = 1'b1;
				if (pend_v_q) begin
					emit_d = pend_q;
					emit_d.last = 1'b1;
				end
			end
			S_PURGE: begin
				sel_idx = fi;
				if (pmatch) cmd.op = C_DISCARD;
				if (cnt_q == LAST_IDX) emit = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			mstep_q <= '0;
			mru_q <= LAST_IDX;
			hit_total_q <= '0;
			k_q <= '0;
			pend_v_q <= 1'b0;
			res_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			res_v_q <= emit;
			case (state_q)
				S_IDLE: begin
					cnt_q <= '0;
					mstep_q <= '0;
					k_q <= '0;
					pend_v_q <= 1'b0;
				end
				S_GET: begin
					if (hit_any) begin
						hit_total_q <= hit_total_q + 32'd1;
						mru_q <= hit_idx;
					end
				end
				S_MOVE: mstep_q <= mstep_q + 3'd1;
				S_VICT: begin
					if (cand_ok) mru_q <= cand;
					cnt_q <= cnt_q + 1'b1;
				end
				S_FLUSH: begin
					if (fmatch) begin
						pend_v_q <= 1'b1;
						k_q <= k_q + 1'b1;
					end
					cnt_q <= cnt_q + 1'b1;
				end
				S_PURGE: begin
					if (pmatch && mru_q == fi) mru_q <= prv[fi];
					cnt_q <= cnt_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		res_q <= emit_d;
		if (state_q == S_IDLE && start) req_q <= req;
		if (state_q == S_GET) begin
			h_q <= hit_any ? hit_idx : mru_q;
			n_q <= nxt[hit_idx];
			p_q <= prv[hit_idx];
			m_q <= mru_q;
			nm_q <= nxt[mru_q];
		end
		if (state_q == S_VICT) h_q <= cand;
		if (state_q == S_FLUSH && fmatch) begin
			pend_q <= '{buffer_index: 4'(fi), writeback_needed: 1'b1,
				writeback_file: fv.file, writeback_record: fv.rec,
				hits_so_far: hit_total_q, default: '0};
		end
	end

	assign busy = (state_q != S_IDLE);
	assign result_valid = res_v_q;
	assign result = res_q;

endmodule
